### design/byte_fifo_drop_oldest_defines.svh
// ---------------------------------------------------------------------------
// Byte FIFO drop-oldest assertion macros
// Shared property macros for the controller and datapath checks.
// ---------------------------------------------------------------------------
`ifndef BYTE_FIFO_DROP_OLDEST_DEFINES_SVH
`define BYTE_FIFO_DROP_OLDEST_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define BFDO_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked outside of reset.
`define BFDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

### design/bfdo_pkg.sv
// ---------------------------------------------------------------------------
// Byte FIFO drop-oldest package
// Shared sizes, action codes and controller/datapath command structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfdo_pkg;

   // Number of slots in the ring; one slot always stays empty.
   localparam int DEPTH = 128;
   localparam int ADDR_W = $clog2(DEPTH);

   // Widths of the transaction fields.
   localparam int ACTION_W = 2;
   localparam int DATA_W = 8;
   localparam int COUNT_FIELD_W = 7;

   // Byte returned when no stored byte is delivered.
   localparam logic [DATA_W-1:0] EMPTY_BYTE = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_GET   = 2'd1,
      ACT_PEEK  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic put;       // store a byte, dropping the oldest when full
      logic clear;     // reset both pointers
      logic pop;       // advance the read pointer after a get
      logic load_imm;  // load a result that carries no stored byte
      logic load_mem;  // load a result with the byte read from the store
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
   } dp_sts_type;

endpackage

### design/bfdo_req_if.sv
// ---------------------------------------------------------------------------
// Byte FIFO drop-oldest request channel
// Valid/ready channel carrying one action and its data byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bfdo_req_if;
   logic                               valid;
   logic                               ready;
   logic [bfdo_pkg::ACTION_W-1:0]      action;
   logic [bfdo_pkg::DATA_W-1:0]        data_in;

   modport source (output valid, output action, output data_in, input ready);
   modport sink   (input valid, input action, input data_in, output ready);
endinterface

### design/bfdo_rsp_if.sv
// ---------------------------------------------------------------------------
// Byte FIFO drop-oldest response channel
// Valid/ready channel carrying the result of one action.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bfdo_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [bfdo_pkg::DATA_W-1:0]           data_out;
   logic                                  data_valid;
   logic                                  dropped_oldest;
   logic [bfdo_pkg::COUNT_FIELD_W-1:0]    bytes_available;
   logic [bfdo_pkg::COUNT_FIELD_W-1:0]    bytes_free;

   modport source (output valid, output data_out, output data_valid,
                   output dropped_oldest, output bytes_available, output bytes_free,
                   input ready);
   modport sink   (input valid, input data_out, input data_valid,
                   input dropped_oldest, input bytes_available, input bytes_free,
                   output ready);
endinterface

### design/byte_fifo_drop_oldest.sv
// ---------------------------------------------------------------------------
// Byte FIFO with drop-oldest policy
// Ring buffer of bytes taking put, get, peek and clear actions.
// ---------------------------------------------------------------------------
//
// Channel   Modport  Direction  Contents
// req_chan  sink     in         action, data_in
// rsp_chan  source   out        data_out, data_valid, dropped_oldest,
//                               bytes_available, bytes_free
//
// A put, a clear, or a get or peek on an empty buffer loads the result register
// on acceptance. A get or peek that finds a byte passes through a fetch state,
// because the byte store has a registered read port that is read at the read pointer.
// Reset is synchronous and active high; it zeroes both pointers, and the
// byte store itself is not cleared because only held entries are ever read.
// A new transaction is taken while a result waits, as long as that result
// is taken in the same cycle; otherwise the request side stalls.
`timescale 1ns / 1ps

module byte_fifo_drop_oldest (
   input  logic         clock,
   input  logic         reset,
   bfdo_req_if.sink     req_chan,
   bfdo_rsp_if.source   rsp_chan
);

   // Commands and status between the controller and the datapath.
   bfdo_pkg::dp_cmd_type   cmd;
   bfdo_pkg::dp_sts_type   sts;

   // The controller decides what each request transaction does and tracks
   // whether the result register holds an undelivered transaction.
   bfdo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_action (req_chan.action),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the byte store, both pointers and the result fields.
   bfdo_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .data_in         (req_chan.data_in),
      .data_out        (rsp_chan.data_out),
      .data_valid      (rsp_chan.data_valid),
      .dropped_oldest  (rsp_chan.dropped_oldest),
      .bytes_available (rsp_chan.bytes_available),
      .bytes_free      (rsp_chan.bytes_free)
   );

endmodule

### design/bfdo_dpath.sv
// ---------------------------------------------------------------------------
// Byte FIFO drop-oldest datapath
// Byte store, ring pointers, occupancy math and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_fifo_drop_oldest_defines.svh"

module bfdo_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bfdo_pkg::dp_cmd_type                  cmd,
   output bfdo_pkg::dp_sts_type                  sts,
   input  logic [bfdo_pkg::DATA_W-1:0]           data_in,
   output logic [bfdo_pkg::DATA_W-1:0]           data_out,
   output logic                                  data_valid,
   output logic                                  dropped_oldest,
   output logic [bfdo_pkg::COUNT_FIELD_W-1:0]    bytes_available,
   output logic [bfdo_pkg::COUNT_FIELD_W-1:0]    bytes_free
);

   localparam int AW = bfdo_pkg::ADDR_W;
   localparam int EXT_W = (AW > bfdo_pkg::COUNT_FIELD_W) ? AW : bfdo_pkg::COUNT_FIELD_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(bfdo_pkg::DEPTH - 1);

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   // Bytes held between the two pointers, modulo the ring size.
   function automatic logic [AW-1:0] held_of(input logic [AW-1:0] wr, input logic [AW-1:0] rd);
      logic [AW:0] wrap;
      wrap = {1'b0, wr} + (AW + 1)'(bfdo_pkg::DEPTH) - {1'b0, rd};
      return (wr >= rd) ? (wr - rd) : wrap[AW-1:0];
   endfunction

   // Low bits of a count as carried in the result fields.
   function automatic logic [bfdo_pkg::COUNT_FIELD_W-1:0] to_field(input logic [AW-1:0] c);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(c);
      return ext[bfdo_pkg::COUNT_FIELD_W-1:0];
   endfunction

   logic [bfdo_pkg::DATA_W-1:0]          store_ff [bfdo_pkg::DEPTH];
   logic [bfdo_pkg::DATA_W-1:0]          rd_data_ff;
   logic [AW-1:0]                        wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]                        rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]                        held, held_next, free_next;
   logic                                 full;

   logic [bfdo_pkg::DATA_W-1:0]          data_out_ff;
   logic                                 data_valid_ff;
   logic                                 dropped_ff;
   logic [bfdo_pkg::COUNT_FIELD_W-1:0]   avail_ff;
   logic [bfdo_pkg::COUNT_FIELD_W-1:0]   free_ff;

   assign held = held_of(wr_ptr_ff, rd_ptr_ff);
   assign full = (held == LAST_SLOT);
   assign sts.empty = (held == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (cmd.clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
      end else if (cmd.put) begin
         wr_ptr_in = next_slot(wr_ptr_ff);
         if (full) begin
            rd_ptr_in = next_slot(rd_ptr_ff);
         end
      end else if (cmd.pop) begin
         rd_ptr_in = next_slot(rd_ptr_ff);
      end
   end

   assign held_next = held_of(wr_ptr_in, rd_ptr_in);
   assign free_next = LAST_SLOT - held_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Byte store: one write port, one registered read port at the read pointer.
   always_ff @(posedge clock) begin
      if (cmd.put) begin
         store_ff[wr_ptr_ff] <= data_in;
      end
      rd_data_ff <= store_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_mem) begin
         data_out_ff   <= rd_data_ff;
         data_valid_ff <= 1'b1;
         dropped_ff    <= 1'b0;
         avail_ff      <= to_field(held_next);
         free_ff       <= to_field(free_next);
      end else if (cmd.load_imm) begin
         data_out_ff   <= bfdo_pkg::EMPTY_BYTE;
         data_valid_ff <= 1'b0;
         dropped_ff    <= cmd.put && full;
         avail_ff      <= to_field(held_next);
         free_ff       <= to_field(free_next);
      end
   end

   assign data_out        = data_out_ff;
   assign data_valid      = data_valid_ff;
   assign dropped_oldest  = dropped_ff;
   assign bytes_available = avail_ff;
   assign bytes_free      = free_ff;

   `BFDO_ASSERT_NEXT(a_put_full_stays_full, clock, reset, cmd.put && full, held == LAST_SLOT)
   `BFDO_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear, sts.empty)
   `BFDO_ASSERT_NEXT(a_mem_result_valid, clock, reset, cmd.load_mem, data_valid && !dropped_oldest)

endmodule

### design/bfdo_ctrl.sv
// ---------------------------------------------------------------------------
// Byte FIFO drop-oldest controller
// Sequences each action and owns the request and response handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_fifo_drop_oldest_defines.svh"

module bfdo_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bfdo_pkg::ACTION_W-1:0]      req_action,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bfdo_pkg::dp_cmd_type               cmd,
   input  bfdo_pkg::dp_sts_type               sts
);

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   state_type              state_ff, state_in;
   logic                   is_get_ff, is_get_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic                   load;
   bfdo_pkg::action_type   act;

   assign act       = bfdo_pkg::action_type'(req_action);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign load      = cmd.load_imm || cmd.load_mem;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      is_get_in = is_get_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (act)
                  bfdo_pkg::ACT_PUT: begin
                     cmd.put      = 1'b1;
                     cmd.load_imm = 1'b1;
                  end
                  bfdo_pkg::ACT_CLEAR: begin
                     cmd.clear    = 1'b1;
                     cmd.load_imm = 1'b1;
                  end
                  bfdo_pkg::ACT_GET, bfdo_pkg::ACT_PEEK: begin
                     if (sts.empty) begin
                        cmd.load_imm = 1'b1;
                     end else begin
                        state_in  = ST_FETCH;
                        is_get_in = (act == bfdo_pkg::ACT_GET);
                     end
                  end
                  default: begin
                     cmd.load_imm = 1'b1;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            cmd.load_mem = 1'b1;
            cmd.pop      = is_get_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         is_get_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_get_ff    <= is_get_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BFDO_ASSERT_IMP(a_no_result_overwrite, clock, reset, load, !rsp_valid_ff || rsp_ready)
   `BFDO_ASSERT_IMP(a_fetch_output_free, clock, reset, state_ff == ST_FETCH, !rsp_valid_ff)
   `BFDO_ASSERT_NEXT(a_read_goes_to_fetch, clock, reset,
      accept && !sts.empty && (act == bfdo_pkg::ACT_GET || act == bfdo_pkg::ACT_PEEK),
      state_ff == ST_FETCH)

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte FIFO drop-oldest testbench
// Sends put, get, peek and clear transactions through the request channel
// with random idle gaps on both sides. It checks every result field against
// typed results or a ring-buffer predictor: first a short table of directed
// actions, then phases of random actions that fill, drain and churn the buffer.
// ---------------------------------------------------------------------------

module tb;

   localparam int RANDOM_ACTIONS = 1100;
   localparam int DIRECTED_ROWS = 22;

   // One result transaction, field by field.
   typedef struct packed {
      logic [bfdo_pkg::DATA_W-1:0]        data_out;
      logic                               data_valid;
      logic                               dropped_oldest;
      logic [bfdo_pkg::COUNT_FIELD_W-1:0] bytes_available;
      logic [bfdo_pkg::COUNT_FIELD_W-1:0] bytes_free;
   } fifo_result_type;

   // A directed action; where has_result is set the result is typed in.
   typedef struct {
      bfdo_pkg::action_type act;
      logic [7:0]           din;
      bit                   has_result;
      fifo_result_type      result;
   } directed_row_type;

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIX,
      MODE_STEADY
   } traffic_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bfdo_req_if req_bus ();
   bfdo_rsp_if rsp_bus ();

   byte_fifo_drop_oldest u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   // Predicted ring-buffer state.
   logic [bfdo_pkg::DATA_W-1:0] shadow_bytes [bfdo_pkg::DEPTH];
   int unsigned                 shadow_wr = 0;
   int unsigned                 shadow_rd = 0;

   fifo_result_type awaited_results [$];
   int              mismatch_count = 0;
   bit              no_gaps = 1'b0;

   // Directed actions: empty-buffer reads, extreme bytes, ordering, clear.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{bfdo_pkg::ACT_GET,   8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd0, 7'd127}},
      '{bfdo_pkg::ACT_PEEK,  8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd0, 7'd127}},
      '{bfdo_pkg::ACT_CLEAR, 8'h5A, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd0, 7'd127}},
      '{bfdo_pkg::ACT_PUT,   8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd1, 7'd126}},
      '{bfdo_pkg::ACT_PUT,   8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd2, 7'd125}},
      '{bfdo_pkg::ACT_PUT,   8'h80, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd3, 7'd124}},
      '{bfdo_pkg::ACT_PEEK,  8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 7'd3, 7'd124}},
      '{bfdo_pkg::ACT_GET,   8'h7F, 1'b1, '{8'h00, 1'b1, 1'b0, 7'd2, 7'd125}},
      '{bfdo_pkg::ACT_GET,   8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0, 7'd1, 7'd126}},
      '{bfdo_pkg::ACT_PEEK,  8'h01, 1'b1, '{8'h80, 1'b1, 1'b0, 7'd1, 7'd126}},
      '{bfdo_pkg::ACT_GET,   8'hFE, 1'b1, '{8'h80, 1'b1, 1'b0, 7'd0, 7'd127}},
      '{bfdo_pkg::ACT_GET,   8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd0, 7'd127}},
      '{bfdo_pkg::ACT_PUT,   8'h01, 1'b0, '0},
      '{bfdo_pkg::ACT_PUT,   8'hFE, 1'b0, '0},
      '{bfdo_pkg::ACT_CLEAR, 8'hA5, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd0, 7'd127}},
      '{bfdo_pkg::ACT_PEEK,  8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd0, 7'd127}},
      '{bfdo_pkg::ACT_GET,   8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd0, 7'd127}},
      '{bfdo_pkg::ACT_PUT,   8'h55, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd1, 7'd126}},
      '{bfdo_pkg::ACT_GET,   8'h00, 1'b1, '{8'h55, 1'b1, 1'b0, 7'd0, 7'd127}},
      '{bfdo_pkg::ACT_PUT,   8'hAA, 1'b0, '0},
      '{bfdo_pkg::ACT_PEEK,  8'h33, 1'b0, '0},
      '{bfdo_pkg::ACT_CLEAR, 8'hCC, 1'b0, '0}
   };

   function automatic int unsigned ring_next(input int unsigned ptr);
      return (ptr + 1 >= bfdo_pkg::DEPTH) ? 0 : ptr + 1;
   endfunction

   function automatic int unsigned ring_held();
      return (shadow_wr >= shadow_rd) ? shadow_wr - shadow_rd
                                      : shadow_wr + bfdo_pkg::DEPTH - shadow_rd;
   endfunction

   // Applies one action to the shadow ring and returns the result it gives.
   function automatic fifo_result_type fifo_predict(
         input bfdo_pkg::action_type act,
         input logic [bfdo_pkg::DATA_W-1:0] din);
      fifo_result_type res;
      int unsigned     held;
      res = '{bfdo_pkg::EMPTY_BYTE, 1'b0, 1'b0, '0, '0};
      held = ring_held();
      case (act)
         bfdo_pkg::ACT_PUT: begin
            // A full ring loses its oldest byte to make room.
            if (held >= bfdo_pkg::DEPTH - 1) begin
               shadow_rd = ring_next(shadow_rd);
               res.dropped_oldest = 1'b1;
            end
            shadow_bytes[shadow_wr] = din;
            shadow_wr = ring_next(shadow_wr);
         end
         bfdo_pkg::ACT_GET: begin
            if (held > 0) begin
               res.data_out = shadow_bytes[shadow_rd];
               res.data_valid = 1'b1;
               shadow_rd = ring_next(shadow_rd);
            end
         end
         bfdo_pkg::ACT_PEEK: begin
            if (held > 0) begin
               res.data_out = shadow_bytes[shadow_rd];
               res.data_valid = 1'b1;
            end
         end
         default: begin
            shadow_wr = 0;
            shadow_rd = 0;
         end
      endcase
      held = ring_held();
      res.bytes_available = bfdo_pkg::COUNT_FIELD_W'(held);
      res.bytes_free = bfdo_pkg::COUNT_FIELD_W'(bfdo_pkg::DEPTH - 1 - held);
      return res;
   endfunction

   // Idle length: mostly none, sometimes short, rarely a long pause.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps)
         return 0;
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic bfdo_pkg::action_type pick_action(input traffic_mode_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (roll < 92) return bfdo_pkg::ACT_PUT;
            if (roll < 96) return bfdo_pkg::ACT_GET;
            return bfdo_pkg::ACT_PEEK;
         end
         MODE_DRAIN: begin
            if (roll < 70) return bfdo_pkg::ACT_GET;
            if (roll < 85) return bfdo_pkg::ACT_PEEK;
            if (roll < 98) return bfdo_pkg::ACT_PUT;
            return bfdo_pkg::ACT_CLEAR;
         end
         default: begin
            if (roll < 42) return bfdo_pkg::ACT_PUT;
            if (roll < 77) return bfdo_pkg::ACT_GET;
            if (roll < 97) return bfdo_pkg::ACT_PEEK;
            return bfdo_pkg::ACT_CLEAR;
         end
      endcase
   endfunction

   // Drives one request transaction from the falling edge and waits for it
   // to be taken. Valid gets a single assignment per falling edge.
   task automatic send_action(input bfdo_pkg::action_type act,
                              input logic [bfdo_pkg::DATA_W-1:0] din,
                              input bit has_result, input fifo_result_type result);
      int              idle;
      fifo_result_type predicted;
      idle = gap_length();
      if (idle > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (idle - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.data_in <= din;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = fifo_predict(act, din);
      awaited_results.push_back(has_result ? result : predicted);
   endtask

   task automatic wait_drained();
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result monitor: every accepted result is matched against the oldest
   // expectation.
   always @(posedge clock) begin
      fifo_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_results.size() == 0) begin
            $error("result transaction arrived with no expectation pending");
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("data_out", want.data_out, rsp_bus.data_out);
            check_field("data_valid", want.data_valid, rsp_bus.data_valid);
            check_field("dropped_oldest", want.dropped_oldest, rsp_bus.dropped_oldest);
            check_field("bytes_available", want.bytes_available, rsp_bus.bytes_available);
            check_field("bytes_free", want.bytes_free, rsp_bus.bytes_free);
         end
      end
   end

   // Result side back-pressure: random stalls between short runs of ready.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = gap_length();
         if (stall > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
   end

   // Stimulus: reset, the directed table, then phases of random traffic.
   initial begin
      traffic_mode_type mode;
      int               phase;
      int               sent;
      int               phase_len;
      req_bus.valid = 1'b0;
      req_bus.action = bfdo_pkg::ACT_PUT;
      req_bus.data_in = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_action(directed_rows[i].act, directed_rows[i].din,
                     directed_rows[i].has_result, directed_rows[i].result);

      // Each phase starts from a quiet block: the sender holds off until
      // every outstanding result has come back.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ACTIONS) begin
         mode = traffic_mode_type'(phase % 4);
         phase_len = (mode == MODE_FILL) ? 180 : $urandom_range(100, 160);
         if (phase_len > RANDOM_ACTIONS - sent)
            phase_len = RANDOM_ACTIONS - sent;
         @(negedge clock);
         req_bus.valid <= 1'b0;
         wait_drained();
         no_gaps = (mode == MODE_STEADY);
         repeat (phase_len) begin
            send_action(pick_action(mode), bfdo_pkg::DATA_W'($urandom_range(0, 255)),
                        1'b0, '0);
            sent++;
         end
         no_gaps = 1'b0;
         phase++;
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #6_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/bfdo_pkg.sv
design/bfdo_req_if.sv
design/bfdo_rsp_if.sv
design/bfdo_dpath.sv
design/bfdo_ctrl.sv
design/byte_fifo_drop_oldest.sv
sim/tb.sv
